// ===== hw/rtl/vgoi_pkg.sv =====
// Package with the shared types and constants of the voxel grid occupancy index.
package vgoi_pkg;

  localparam int RES_W     = 20;  // unsigned Q12.8 voxel edge length
  localparam int SHAPE_W   = 7;   // voxel count per axis
  localparam int QUO_W     = 7;   // quotient bits of one axis division
  localparam int PROD_W    = RES_W + SHAPE_W;      // shape * res
  localparam int REM_W     = PROD_W + 1;           // 2 * shape * res
  localparam int SCALE_W   = 2 * SHAPE_W;          // sy * sz
  localparam int BASE_W    = QUO_W + SCALE_W;      // q * scale
  localparam int IDX_W     = 18;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 3;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  localparam logic [RES_W-1:0]   RES_RESET   = 20'd3840;
  localparam logic [SHAPE_W-1:0] SHAPE_RESET = 7'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RES_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_Z = 3'd5;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } vgoi_axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_STORE,
    ST_EMIT
  } vgoi_state_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][RES_W-1:0]   res;
    logic [NUM_AXES-1:0][SHAPE_W-1:0] shape;
  } vgoi_cfg_t;

  typedef struct packed {
    logic                load_in;
    logic                prep;
    logic                check;
    logic                div_step;
    logic                mul;
    logic                store;
    logic                emit;
    logic                miss;
    logic                last;
    vgoi_axis_t          axis;
    logic [NUM_AXES-1:0] sel;
  } vgoi_cmd_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] have_lo;
    logic [NUM_AXES-1:0] have_hi;
    logic                out_busy;
  } vgoi_sts_t;

endpackage

// ===== hw/rtl/vgoi_cfg.sv =====
// Configuration register file: voxel resolutions and grid shape per axis.
module vgoi_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vgoi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgoi_pkg::RES_W-1:0]        cfg_data,
  output vgoi_pkg::vgoi_cfg_t               cfg_o
);

  vgoi_pkg::vgoi_cfg_t regs_r;
  vgoi_pkg::vgoi_cfg_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        vgoi_pkg::REG_RES_X:   regs_nxt.res[0]   = cfg_data;
        vgoi_pkg::REG_RES_Y:   regs_nxt.res[1]   = cfg_data;
        vgoi_pkg::REG_RES_Z:   regs_nxt.res[2]   = cfg_data;
        vgoi_pkg::REG_SHAPE_X: regs_nxt.shape[0] = cfg_data[vgoi_pkg::SHAPE_W-1:0];
        vgoi_pkg::REG_SHAPE_Y: regs_nxt.shape[1] = cfg_data[vgoi_pkg::SHAPE_W-1:0];
        vgoi_pkg::REG_SHAPE_Z: regs_nxt.shape[2] = cfg_data[vgoi_pkg::SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vgoi_pkg::NUM_AXES; i++) begin
        regs_r.res[i]   <= vgoi_pkg::RES_RESET;
        regs_r.shape[i] <= vgoi_pkg::SHAPE_RESET;
      end
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== hw/rtl/vgoi_dp.sv =====
// Datapath: per-axis offset, range check, shared divider, index bases and result register.
module vgoi_dp #(
  parameter int MAX_DIM     = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vgoi_pkg::vgoi_cfg_t               cfg_i,
  input  vgoi_pkg::vgoi_cmd_t               cmd,
  output vgoi_pkg::vgoi_sts_t               sts,
  input  logic signed [COORD_WIDTH-1:0]     in_center_x,
  input  logic signed [COORD_WIDTH-1:0]     in_center_y,
  input  logic signed [COORD_WIDTH-1:0]     in_center_z,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  input  logic signed [COORD_WIDTH-1:0]     in_point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [vgoi_pkg::IDX_W-1:0]        out_voxel_index,
  output logic                              out_last
);

  localparam int CW        = COORD_WIDTH;
  localparam int DIFF_W    = CW + 2;
  localparam int DW        = ((DIFF_W > vgoi_pkg::REM_W) ? DIFF_W : vgoi_pkg::REM_W) + 1;
  localparam int SHAPE_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam int SUM_W     = vgoi_pkg::BASE_W + 2;

  localparam logic [vgoi_pkg::SHAPE_W-1:0] SHAPE_CAP_V = vgoi_pkg::SHAPE_W'(SHAPE_CAP);

  // Latched coordinates of the transaction in flight.
  logic [vgoi_pkg::NUM_AXES-1:0][CW-1:0] ctr_r;
  logic [vgoi_pkg::NUM_AXES-1:0][CW-1:0] pnt_r;

  logic [vgoi_pkg::NUM_AXES-1:0][vgoi_pkg::SHAPE_W-1:0] shape_c;

  logic [DIFF_W-1:0]              diff_r;
  logic [vgoi_pkg::PROD_W-1:0]    prod_r;
  logic [vgoi_pkg::SCALE_W-1:0]   syz_r;
  logic [vgoi_pkg::REM_W-1:0]     rem_r;
  logic [vgoi_pkg::REM_W-1:0]     dvs_r;
  logic [vgoi_pkg::QUO_W-1:0]     quo_r;
  logic                           ok_r;
  logic [vgoi_pkg::BASE_W-1:0]    mulq_r;
  logic [vgoi_pkg::NUM_AXES-1:0]  have_lo_r;
  logic [vgoi_pkg::NUM_AXES-1:0]  have_hi_r;
  logic [vgoi_pkg::NUM_AXES-1:0][vgoi_pkg::BASE_W-1:0] base_lo_r;
  logic [vgoi_pkg::NUM_AXES-1:0][vgoi_pkg::BASE_W-1:0] base_hi_r;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [vgoi_pkg::IDX_W-1:0]     out_index_r;
  logic                           out_last_r;

  logic [CW-1:0]                  ctr_a;
  logic [CW-1:0]                  pnt_a;
  logic [vgoi_pkg::RES_W-1:0]     res_a;
  logic [vgoi_pkg::SHAPE_W-1:0]   shape_a;
  logic [vgoi_pkg::SCALE_W-1:0]   scale_a;
  logic [CW:0]                    dpc;
  logic [DW-1:0]                  d_val;
  logic [DW-1:0]                  d_bound;
  logic                           d_ok;
  logic                           take;
  logic [vgoi_pkg::NUM_AXES-1:0][vgoi_pkg::BASE_W-1:0] base_sel;
  logic [SUM_W-1:0]               idx_sum;

  // A shape above the supported grid size is saturated.
  always_comb begin
    for (int i = 0; i < vgoi_pkg::NUM_AXES; i++) begin
      shape_c[i] = (cfg_i.shape[i] > SHAPE_CAP_V) ? SHAPE_CAP_V : cfg_i.shape[i];
    end
  end

  assign ctr_a   = ctr_r[cmd.axis];
  assign pnt_a   = pnt_r[cmd.axis];
  assign res_a   = cfg_i.res[cmd.axis];
  assign shape_a = shape_c[cmd.axis];

  always_comb begin
    unique case (cmd.axis)
      vgoi_pkg::AXIS_X: scale_a = syz_r;
      vgoi_pkg::AXIS_Y: scale_a = {{vgoi_pkg::SHAPE_W{1'b0}}, shape_c[2]};
      vgoi_pkg::AXIS_Z: scale_a = vgoi_pkg::SCALE_W'(1);
      default:          scale_a = '0;
    endcase
  end

  assign dpc = {pnt_a[CW-1], pnt_a} - {ctr_a[CW-1], ctr_a};

  // Doubled offset of the point from the grid's lower corner.
  assign d_val   = {{(DW-DIFF_W){diff_r[DIFF_W-1]}}, diff_r}
                 + {{(DW-vgoi_pkg::PROD_W){1'b0}}, prod_r};
  assign d_bound = {{(DW-vgoi_pkg::PROD_W-1){1'b0}}, prod_r, 1'b0};
  assign d_ok    = !d_val[DW-1] && (d_val <= d_bound) && (res_a != '0) && (shape_a != '0);

  assign take = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ctr_r[0] <= in_center_x;
      ctr_r[1] <= in_center_y;
      ctr_r[2] <= in_center_z;
      pnt_r[0] <= in_point_x;
      pnt_r[1] <= in_point_y;
      pnt_r[2] <= in_point_z;
    end
    syz_r <= vgoi_pkg::SCALE_W'(shape_c[1]) * vgoi_pkg::SCALE_W'(shape_c[2]);
    if (cmd.prep) begin
      diff_r <= {dpc, 1'b0};
      prod_r <= vgoi_pkg::PROD_W'(shape_a) * vgoi_pkg::PROD_W'(res_a);
    end
    if (cmd.check) begin
      ok_r  <= d_ok;
      rem_r <= d_val[vgoi_pkg::REM_W-1:0];
      dvs_r <= {{(vgoi_pkg::REM_W-vgoi_pkg::RES_W-vgoi_pkg::QUO_W){1'b0}}, res_a,
                {vgoi_pkg::QUO_W{1'b0}}};
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (take) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= {quo_r[vgoi_pkg::QUO_W-2:0], take};
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.mul) begin
      mulq_r <= vgoi_pkg::BASE_W'(quo_r) * vgoi_pkg::BASE_W'(scale_a);
    end
    if (cmd.store) begin
      base_hi_r[cmd.axis] <= mulq_r;
      base_lo_r[cmd.axis] <= mulq_r - vgoi_pkg::BASE_W'(scale_a);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_lo_r <= '0;
      have_hi_r <= '0;
    end else if (cmd.mul) begin
      have_lo_r[cmd.axis] <= ok_r && (rem_r == '0) && (quo_r != '0);
      have_hi_r[cmd.axis] <= ok_r && (quo_r < shape_a);
    end
  end

  always_comb begin
    for (int i = 0; i < vgoi_pkg::NUM_AXES; i++) begin
      base_sel[i] = (cmd.sel[i] || !have_lo_r[i]) ? base_hi_r[i] : base_lo_r[i];
    end
  end

  assign idx_sum = SUM_W'(base_sel[0]) + SUM_W'(base_sel[1]) + SUM_W'(base_sel[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r   <= !cmd.miss;
      out_index_r <= cmd.miss ? '0 : idx_sum[vgoi_pkg::IDX_W-1:0];
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_voxel_index = out_index_r;
  assign out_last        = out_last_r;

  assign sts.have_lo  = have_lo_r;
  assign sts.have_hi  = have_hi_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

// ===== hw/rtl/vgoi_ctrl.sv =====
// Controller: sequences the three axis divisions and walks the candidate voxels.
module vgoi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vgoi_pkg::vgoi_sts_t sts,
  output vgoi_pkg::vgoi_cmd_t cmd
);

  vgoi_pkg::vgoi_state_t                state_r, state_nxt;
  vgoi_pkg::vgoi_axis_t                 axis_r, axis_nxt;
  logic [vgoi_pkg::DIV_CNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic [vgoi_pkg::NUM_AXES-1:0]        sel_r, sel_nxt;
  logic [vgoi_pkg::NUM_AXES-1:0]        two;
  logic [vgoi_pkg::NUM_AXES-1:0]        at_end;
  logic                                 miss;

  assign two    = sts.have_lo & sts.have_hi;
  assign at_end = sel_r | ~two;
  assign miss   = |(~(sts.have_lo | sts.have_hi));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vgoi_pkg::ST_IDLE;
      axis_r    <= vgoi_pkg::AXIS_X;
      div_cnt_r <= '0;
      sel_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      div_cnt_r <= div_cnt_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    div_cnt_nxt = div_cnt_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.axis    = axis_r;
    cmd.sel     = sel_r;
    in_ready    = 1'b0;
    unique case (state_r)
      vgoi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          axis_nxt    = vgoi_pkg::AXIS_X;
          state_nxt   = vgoi_pkg::ST_LOAD;
        end
      end
      vgoi_pkg::ST_LOAD: begin
        cmd.prep  = 1'b1;
        state_nxt = vgoi_pkg::ST_CHECK;
      end
      vgoi_pkg::ST_CHECK: begin
        cmd.check   = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = vgoi_pkg::ST_DIV;
      end
      vgoi_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == vgoi_pkg::DIV_LAST) begin
          state_nxt = vgoi_pkg::ST_MUL;
        end
      end
      vgoi_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = vgoi_pkg::ST_STORE;
      end
      vgoi_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (axis_r == vgoi_pkg::AXIS_Z) begin
          sel_nxt   = '0;
          state_nxt = vgoi_pkg::ST_EMIT;
        end else begin
          axis_nxt  = (axis_r == vgoi_pkg::AXIS_X) ? vgoi_pkg::AXIS_Y : vgoi_pkg::AXIS_Z;
          state_nxt = vgoi_pkg::ST_LOAD;
        end
      end
      vgoi_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (miss) begin
            cmd.miss  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = vgoi_pkg::ST_IDLE;
          end else if (&at_end) begin
            cmd.last  = 1'b1;
            sel_nxt   = '0;
            state_nxt = vgoi_pkg::ST_IDLE;
          end else if (!at_end[2]) begin
            sel_nxt[2] = 1'b1;
          end else if (!at_end[1]) begin
            sel_nxt[2] = 1'b0;
            sel_nxt[1] = 1'b1;
          end else begin
            sel_nxt[2] = 1'b0;
            sel_nxt[1] = 1'b0;
            sel_nxt[0] = 1'b1;
          end
        end
      end
      default: state_nxt = vgoi_pkg::ST_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == vgoi_pkg::ST_LOAD && axis_r == vgoi_pkg::AXIS_X)
    else $error("accepted transaction did not start the x axis");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.last |=> state_r == vgoi_pkg::ST_IDLE)
    else $error("final result did not return the controller to idle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded while the output register was still held");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vgoi_pkg::ST_DIV |-> div_cnt_r <= vgoi_pkg::DIV_LAST)
    else $error("divider step count overran the quotient width");

endmodule

// ===== hw/rtl/voxel_grid_occupancy_index.sv =====
// Top level of the voxel grid occupancy index: register file, controller and datapath.
//
//   Channel   Ports                                   Direction   Transaction
//   in        in_valid/in_ready, in_center_*, in_point_*   input  one query
//   out       out_valid/out_ready, out_hit, out_voxel_index, out_last  output  one voxel
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data     input  one register write
//
// Each query runs the three axes in turn before its first result, then gives one result per
// cycle while the output register is not stalled (1 to 8 results). The shared restoring
// divider handles each axis as offset, range check, 7 quotient steps, index scaling and
// base store. A new query is accepted once the last result of
// the previous one is in the output register. Reset is synchronous and active low and
// restores the configuration to 15.0 voxel length and 32 voxels per axis. A stalled
// output register simply holds the walk over candidate voxels until it is taken.
module voxel_grid_occupancy_index #(
  parameter int MAX_DIM     = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_center_x,
  input  logic signed [COORD_WIDTH-1:0]     in_center_y,
  input  logic signed [COORD_WIDTH-1:0]     in_center_z,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  input  logic signed [COORD_WIDTH-1:0]     in_point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [vgoi_pkg::IDX_W-1:0]        out_voxel_index,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vgoi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgoi_pkg::RES_W-1:0]        cfg_data
);

  vgoi_pkg::vgoi_cfg_t cfg_regs;
  vgoi_pkg::vgoi_cmd_t cmd;
  vgoi_pkg::vgoi_sts_t sts;

  // Register writes land directly; the user keeps the block idle for them, unchecked.
  vgoi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg_regs)
  );

  // The controller owns the handshake on the input side and the candidate walk.
  vgoi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the query, the per-axis candidates and the output register.
  vgoi_dp #(
    .MAX_DIM     (MAX_DIM),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_regs),
    .cmd             (cmd),
    .sts             (sts),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_center_z     (in_center_z),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_voxel_index (out_voxel_index),
    .out_last        (out_last)
  );

endmodule
